// ===== hdl/telnet_iac_line_deframer_core_macros.svh =====
// Assertion macros for the telnet IAC line deframer.
// Included by the top level; needs no other file.
`ifndef TELNET_IAC_LINE_DEFRAMER_CORE_MACROS_SVH
`define TELNET_IAC_LINE_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TILD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TILD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tild_pkg.sv =====
// Shared constants, byte classes, event codes and queue entry type
// for the telnet IAC line deframer. No dependencies.
package tild_pkg;

    // Buffer sizes
    localparam int LINE_MAX    = 64;
    localparam int FW_MAX      = 4096;

    // Derived widths
    localparam int LINE_CNT_W  = $clog2(LINE_MAX + 1);
    localparam int LINE_ADDR_W = $clog2(LINE_MAX);
    localparam int FW_CNT_W    = $clog2(FW_MAX + 1);
    localparam int FW_ADDR_W   = $clog2(FW_MAX);

    // Fixed port widths
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 16;
    localparam int EVENT_W     = 3;
    localparam int LINE_LEN_W  = 7;
    localparam int FW_LEN_W    = 13;

    // Decoupling queue
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    // Telnet bytes
    localparam logic [BYTE_W-1:0] IAC_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] CMD_WILL = 8'hFB;
    localparam logic [BYTE_W-1:0] CMD_DO   = 8'hFD;
    localparam logic [BYTE_W-1:0] CMD_IP   = 8'hF4;
    localparam logic [BYTE_W-1:0] OPT_TM   = 8'h06;
    localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR  = 8'h0D;

    // Byte class found by the front end
    typedef enum logic [2:0] {
        CLS_DATA,
        CLS_EOL,
        CLS_IAC,
        CLS_WILL,
        CLS_DO,
        CLS_IP,
        CLS_TM
    } tild_class_t;

    // Result event codes
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE,
        EV_LINE,
        EV_TM,
        EV_TM_CRLF,
        EV_FW_BYTE,
        EV_FW_DONE,
        EV_ARM_OK,
        EV_ARM_BAD
    } tild_event_t;

    // One classified item as it travels through the queue
    typedef struct packed {
        logic                arm;
        logic                arm_ok;
        logic [FW_CNT_W-1:0] arm_count;
        tild_class_t         cls;
        logic [BYTE_W-1:0]   data;
    } tild_op_t;

endpackage

// ===== hdl/tild_front.sv =====
// Front end: accepts input transfers and classifies each item.
// Depends on tild_pkg.
module tild_front
(
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              mode,
    input  logic [tild_pkg::BYTE_W-1:0]       data_byte,
    input  logic [tild_pkg::COUNT_W-1:0]      block_count,
    input  logic                              q_full,
    output logic                              q_push,
    output tild_pkg::tild_op_t                q_op
);

    // Hold off the sender only when the queue has no room
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // Classify the byte and check the arm request
    always_comb
    begin
        q_op           = '0;
        q_op.arm       = mode;
        q_op.data      = data_byte;
        q_op.arm_ok    = (block_count != '0) &&
                         (32'(block_count) <= 32'(tild_pkg::FW_MAX));
        q_op.arm_count = tild_pkg::FW_CNT_W'(block_count);
        unique case (data_byte)
            tild_pkg::IAC_BYTE: q_op.cls = tild_pkg::CLS_IAC;
            tild_pkg::CMD_WILL: q_op.cls = tild_pkg::CLS_WILL;
            tild_pkg::CMD_DO:   q_op.cls = tild_pkg::CLS_DO;
            tild_pkg::CMD_IP:   q_op.cls = tild_pkg::CLS_IP;
            tild_pkg::OPT_TM:   q_op.cls = tild_pkg::CLS_TM;
            tild_pkg::CHAR_LF,
            tild_pkg::CHAR_CR:  q_op.cls = tild_pkg::CLS_EOL;
            default:            q_op.cls = tild_pkg::CLS_DATA;
        endcase
    end

endmodule

// ===== hdl/tild_fifo.sv =====
// Short queue between front end and back end.
// Depends on tild_pkg.
module tild_fifo
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tild_pkg::tild_op_t   push_op,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output tild_pkg::tild_op_t   head_op
);

    tild_pkg::tild_op_t               slot_reg [tild_pkg::Q_DEPTH];
    logic [tild_pkg::Q_PTR_W-1:0]     wr_ptr_reg;
    logic [tild_pkg::Q_PTR_W-1:0]     wr_ptr_next;
    logic [tild_pkg::Q_PTR_W-1:0]     rd_ptr_reg;
    logic [tild_pkg::Q_PTR_W-1:0]     rd_ptr_next;
    logic [tild_pkg::Q_CNT_W-1:0]     count_reg;
    logic [tild_pkg::Q_CNT_W-1:0]     count_next;

    assign full      = (count_reg == tild_pkg::Q_CNT_W'(tild_pkg::Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_op   = slot_reg[rd_ptr_reg];

    // Pointer and fill updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == tild_pkg::Q_PTR_W'(tild_pkg::Q_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == tild_pkg::Q_PTR_W'(tild_pkg::Q_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ===== hdl/tild_back.sv =====
// Back end: IAC parser state, line and firmware buffers, result register.
// Depends on tild_pkg.
module tild_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  tild_pkg::tild_op_t                  q_op,
    output logic                                q_pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [tild_pkg::EVENT_W-1:0]        event_res,
    output logic [tild_pkg::LINE_LEN_W-1:0]     line_length,
    output logic [tild_pkg::FW_LEN_W-1:0]       fw_length
);

    // Parser and capture state
    logic                               esc_reg,   esc_next;
    logic                               will_reg,  will_next;
    logic                               do_reg,    do_next;
    logic                               intr_reg,  intr_next;
    logic [tild_pkg::LINE_CNT_W-1:0]    line_cnt_reg, line_cnt_next;
    logic [tild_pkg::FW_CNT_W-1:0]      fw_rem_reg,   fw_rem_next;
    logic [tild_pkg::FW_CNT_W-1:0]      fw_idx_reg,   fw_idx_next;

    // Result register
    logic                               out_valid_reg;
    tild_pkg::tild_event_t              ev_reg,   ev_next;
    logic [tild_pkg::LINE_LEN_W-1:0]    llen_reg;
    logic [tild_pkg::FW_LEN_W-1:0]      flen_reg;

    // Step outputs
    logic [tild_pkg::LINE_CNT_W-1:0]    llen_next;
    logic [tild_pkg::FW_CNT_W-1:0]      flen_next;
    logic [tild_pkg::FW_CNT_W-1:0]      fw_idx_inc;
    logic                               line_we;
    logic                               fw_we;

    // Buffers
    logic [tild_pkg::BYTE_W-1:0]        line_mem [tild_pkg::LINE_MAX];
    logic [tild_pkg::BYTE_W-1:0]        fw_mem   [tild_pkg::FW_MAX];

    // Take the next item whenever the result register is free or draining
    assign q_pop = q_valid && (!out_valid_reg || !out_stall);

    assign fw_idx_inc = fw_idx_reg + 1'b1;

    // One item step
    always_comb
    begin
        esc_next      = esc_reg;
        will_next     = will_reg;
        do_next       = do_reg;
        intr_next     = intr_reg;
        line_cnt_next = line_cnt_reg;
        fw_rem_next   = fw_rem_reg;
        fw_idx_next   = fw_idx_reg;
        ev_next       = tild_pkg::EV_NONE;
        llen_next     = '0;
        line_we       = 1'b0;
        fw_we         = 1'b0;

        priority if (q_op.arm)
        begin
            if (q_op.arm_ok)
            begin
                fw_idx_next = '0;
                fw_rem_next = q_op.arm_count;
                ev_next     = tild_pkg::EV_ARM_OK;
            end
            else
            begin
                ev_next = tild_pkg::EV_ARM_BAD;
            end
        end
        else if (fw_rem_reg != '0)
        begin
            // Raw capture bypasses the parser
            fw_we       = 1'b1;
            fw_rem_next = fw_rem_reg - 1'b1;
            if (fw_rem_reg == tild_pkg::FW_CNT_W'(1))
            begin
                ev_next     = tild_pkg::EV_FW_DONE;
                fw_idx_next = '0;
            end
            else
            begin
                ev_next     = tild_pkg::EV_FW_BYTE;
                fw_idx_next = fw_idx_inc;
            end
        end
        else if (esc_reg)
        begin
            esc_next = 1'b0;
            unique case (q_op.cls)
                tild_pkg::CLS_IAC:
                begin
                    // Escaped 0xFF is line data
                    if (line_cnt_reg < tild_pkg::LINE_CNT_W'(tild_pkg::LINE_MAX))
                    begin
                        line_we       = 1'b1;
                        line_cnt_next = line_cnt_reg + 1'b1;
                    end
                end
                tild_pkg::CLS_WILL: will_next = 1'b1;
                tild_pkg::CLS_DO:   do_next   = 1'b1;
                tild_pkg::CLS_IP:   intr_next = 1'b1;
                default:            ;
            endcase
        end
        else if (will_reg)
        begin
            will_next = 1'b0;
        end
        else if (do_reg)
        begin
            do_next = 1'b0;
            if (q_op.cls == tild_pkg::CLS_TM)
            begin
                ev_next = tild_pkg::EV_TM;
                if (intr_reg)
                begin
                    intr_next     = 1'b0;
                    line_cnt_next = '0;
                    ev_next       = tild_pkg::EV_TM_CRLF;
                end
            end
        end
        else if (q_op.cls == tild_pkg::CLS_IAC)
        begin
            esc_next = 1'b1;
        end
        else if (q_op.cls == tild_pkg::CLS_EOL)
        begin
            if (line_cnt_reg != '0)
            begin
                llen_next     = line_cnt_reg;
                line_cnt_next = '0;
                ev_next       = tild_pkg::EV_LINE;
            end
        end
        else
        begin
            // Plain data; bytes past a full line are dropped
            if (line_cnt_reg < tild_pkg::LINE_CNT_W'(tild_pkg::LINE_MAX))
            begin
                line_we       = 1'b1;
                line_cnt_next = line_cnt_reg + 1'b1;
            end
        end

        // Block done reports the block size, otherwise the index after the step
        flen_next = (ev_next == tild_pkg::EV_FW_DONE) ? fw_idx_inc : fw_idx_next;
    end

    // State and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg       <= 1'b0;
            will_reg      <= 1'b0;
            do_reg        <= 1'b0;
            intr_reg      <= 1'b0;
            line_cnt_reg  <= '0;
            fw_rem_reg    <= '0;
            fw_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                esc_reg      <= esc_next;
                will_reg     <= will_next;
                do_reg       <= do_next;
                intr_reg     <= intr_next;
                line_cnt_reg <= line_cnt_next;
                fw_rem_reg   <= fw_rem_next;
                fw_idx_reg   <= fw_idx_next;
            end
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            ev_reg   <= ev_next;
            llen_reg <= tild_pkg::LINE_LEN_W'(llen_next);
            flen_reg <= tild_pkg::FW_LEN_W'(flen_next);
        end
    end

    // Line buffer write port
    always_ff @(posedge clk)
    begin
        if (q_pop && line_we)
        begin
            line_mem[line_cnt_reg[tild_pkg::LINE_ADDR_W-1:0]] <= q_op.data;
        end
    end

    // Firmware buffer write port
    always_ff @(posedge clk)
    begin
        if (q_pop && fw_we)
        begin
            fw_mem[fw_idx_reg[tild_pkg::FW_ADDR_W-1:0]] <= q_op.data;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_res   = ev_reg;
    assign line_length = llen_reg;
    assign fw_length   = flen_reg;

endmodule

// ===== hdl/telnet_iac_line_deframer_core.sv =====
// Telnet IAC line deframer, top level.
// Depends on tild_pkg, tild_front, tild_fifo, tild_back and the macros header.
//
// Input channel (in_valid/in_stall): one item per transfer. mode 0 carries a
// received byte in data_byte; mode 1 arms a raw firmware block of block_count
// bytes. Output channel (out_valid/out_stall): exactly one result per item,
// in order: event_res, line_length (nonzero only for a line-ready event) and
// fw_length.
// Throughput is one item per cycle while the receiver does not stall. An item
// is registered in the two-entry queue after the front end, then the back
// end runs its parser step into the result register; that step sets the rate.
// When the receiver stalls, the result register holds and the queue absorbs
// up to two more items; in_stall rises only when the queue is full, and drops
// in the cycle after an unstalled output cycle.
// Reset clears the parser flags, line count and firmware counters; the line
// and firmware buffers keep stale contents, which are never read back.
`include "telnet_iac_line_deframer_core_macros.svh"

module telnet_iac_line_deframer_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                mode,
    input  logic [tild_pkg::BYTE_W-1:0]         data_byte,
    input  logic [tild_pkg::COUNT_W-1:0]        block_count,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [tild_pkg::EVENT_W-1:0]        event_res,
    output logic [tild_pkg::LINE_LEN_W-1:0]     line_length,
    output logic [tild_pkg::FW_LEN_W-1:0]       fw_length
);

    logic                 q_full;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_not_empty;
    tild_pkg::tild_op_t   push_op;
    tild_pkg::tild_op_t   head_op;

    // Accept and classify
    tild_front u_front
    (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .data_byte   (data_byte),
        .block_count (block_count),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_op        (push_op)
    );

    // Decoupling queue
    tild_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_op   (push_op),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_op   (head_op)
    );

    // Parse, buffer and report
    tild_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_not_empty),
        .q_op        (head_op),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_res   (event_res),
        .line_length (line_length),
        .fw_length   (fw_length)
    );

    // Only a line-ready event carries a line length
    `TILD_ASSERT_IMP(a_len_only_on_line, clk, rst_n,
                     out_valid && (event_res != tild_pkg::EV_LINE),
                     line_length == '0, "line_length set on non-line event")

    // An accepted arm restarts the firmware index
    `TILD_ASSERT_IMP(a_arm_ok_index, clk, rst_n,
                     out_valid && (event_res == tild_pkg::EV_ARM_OK),
                     fw_length == '0, "fw_length not cleared by arm")

    // An unstalled output cycle always leaves room in the queue
    `TILD_ASSERT_NXT(a_no_stall_when_draining, clk, rst_n, !out_stall, !in_stall,
                     "input stalled while output drains")

endmodule

// ===== tb/sv/telnet_iac_line_deframer_core_tb.sv =====
// Self-checking testbench for telnet_iac_line_deframer_core.
// Holds its own deframer predictor and checks every result in order.
// Depends on tild_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module telnet_iac_line_deframer_core_tb;

    // One input item as queued for the driver
    typedef struct {
        logic                         mode;
        logic [tild_pkg::BYTE_W-1:0]  data;
        logic [tild_pkg::COUNT_W-1:0] count;
        logic                         hold;   // wait for all results before sending
    } rx_item_t;

    // One expected result
    typedef struct {
        tild_pkg::tild_event_t           ev;
        logic [tild_pkg::LINE_LEN_W-1:0] line_len;
        logic [tild_pkg::FW_LEN_W-1:0]   fw_len;
    } deframe_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic                            mode = 1'b0;
    logic [tild_pkg::BYTE_W-1:0]     data_byte = '0;
    logic [tild_pkg::COUNT_W-1:0]    block_count = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [tild_pkg::EVENT_W-1:0]    event_res;
    logic [tild_pkg::LINE_LEN_W-1:0] line_length;
    logic [tild_pkg::FW_LEN_W-1:0]   fw_length;

    rx_item_t        pend_q[$];
    deframe_result_t exp_q[$];
    rx_item_t        cur_item;
    logic            drain_next = 1'b0;
    int              n_queued = 0;
    int              n_sent = 0;
    int              n_recv = 0;
    int              errors = 0;
    int              ev_cnt[8];

    // Predictor state
    logic esc_pend = 1'b0;
    logic will_pend = 1'b0;
    logic do_pend = 1'b0;
    logic intr_seen = 1'b0;
    int   line_cnt = 0;
    int   fw_rem = 0;
    int   fw_idx = 0;

    telnet_iac_line_deframer_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .data_byte   (data_byte),
        .block_count (block_count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_res   (event_res),
        .line_length (line_length),
        .fw_length   (fw_length)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Data byte into the line: returns length of a finished line, else 0
    function automatic int line_take(input logic [tild_pkg::BYTE_W-1:0] b);
        int len;
        len = 0;
        if (b == tild_pkg::CHAR_LF || b == tild_pkg::CHAR_CR)
        begin
            if (line_cnt != 0)
            begin
                len = line_cnt;
                line_cnt = 0;
            end
        end
        else if (line_cnt < tild_pkg::LINE_MAX)
        begin
            line_cnt++;
        end
        return len;
    endfunction

    // Deframer step: updates predictor state, returns the expected result
    function automatic deframe_result_t deframe_step(input rx_item_t it);
        deframe_result_t r;
        int len;
        int flen;
        len = 0;
        r.ev = tild_pkg::EV_NONE;
        flen = -1;
        if (it.mode)
        begin
            if (it.count == 0 || it.count > tild_pkg::FW_MAX)
            begin
                r.ev = tild_pkg::EV_ARM_BAD;
            end
            else
            begin
                fw_idx = 0;
                fw_rem = int'(it.count);
                r.ev = tild_pkg::EV_ARM_OK;
            end
        end
        else if (fw_rem != 0)
        begin
            // raw capture bypasses the parser
            fw_idx++;
            fw_rem--;
            if (fw_rem == 0)
            begin
                r.ev = tild_pkg::EV_FW_DONE;
                flen = fw_idx;
                fw_idx = 0;
            end
            else
            begin
                r.ev = tild_pkg::EV_FW_BYTE;
            end
        end
        else if (esc_pend)
        begin
            esc_pend = 1'b0;
            if (it.data == tild_pkg::IAC_BYTE)
                len = line_take(it.data);
            else if (it.data == tild_pkg::CMD_WILL)
                will_pend = 1'b1;
            else if (it.data == tild_pkg::CMD_DO)
                do_pend = 1'b1;
            else if (it.data == tild_pkg::CMD_IP)
                intr_seen = 1'b1;
        end
        else if (will_pend)
        begin
            will_pend = 1'b0;
        end
        else if (do_pend)
        begin
            do_pend = 1'b0;
            if (it.data == tild_pkg::OPT_TM)
            begin
                r.ev = tild_pkg::EV_TM;
                if (intr_seen)
                begin
                    intr_seen = 1'b0;
                    line_cnt = 0;
                    r.ev = tild_pkg::EV_TM_CRLF;
                end
            end
        end
        else if (it.data == tild_pkg::IAC_BYTE)
        begin
            esc_pend = 1'b1;
        end
        else
        begin
            len = line_take(it.data);
        end
        if (len != 0)
            r.ev = tild_pkg::EV_LINE;
        r.line_len = len[tild_pkg::LINE_LEN_W-1:0];
        r.fw_len = (flen >= 0) ? flen[tild_pkg::FW_LEN_W-1:0] : fw_idx[tild_pkg::FW_LEN_W-1:0];
        return r;
    endfunction

    task automatic queue_item(input logic m, input logic [tild_pkg::BYTE_W-1:0] b,
                              input logic [tild_pkg::COUNT_W-1:0] c);
        rx_item_t it;
        it.mode = m;
        it.data = b;
        it.count = c;
        it.hold = drain_next;
        drain_next = 1'b0;
        pend_q.push_back(it);
        n_queued++;
    endtask

    task automatic queue_byte(input logic [tild_pkg::BYTE_W-1:0] b);
        queue_item(1'b0, b, 16'($urandom_range(0, 65535)));
    endtask

    task automatic queue_arm(input logic [tild_pkg::COUNT_W-1:0] c);
        queue_item(1'b1, 8'($urandom_range(0, 255)), c);
    endtask

    task automatic compare_field(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, what, want, got);
        end
    endtask

    // Driver: presents queued items, predicts each transfer on acceptance
    always @(posedge clk or negedge rst_n)
    begin : drive
        logic     idle;
        rx_item_t nxt;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            mode        <= 1'b0;
            data_byte   <= '0;
            block_count <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                exp_q.push_back(deframe_step(cur_item));
                n_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                // no gaps in the middle stretch of the run
                idle = (n_sent >= 250 && n_sent < 400) ? 1'b0 : ($urandom_range(0, 99) < 20);
                if (pend_q.size() != 0 && !idle && !(pend_q[0].hold && exp_q.size() != 0))
                begin
                    nxt = pend_q.pop_front();
                    cur_item = nxt;
                    mode        <= nxt.mode;
                    data_byte   <= nxt.data;
                    block_count <= nxt.count;
                    in_valid    <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin : watch
        deframe_result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                n_recv++;
                if (!$isunknown(event_res))
                    ev_cnt[event_res]++;
                if (exp_q.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: result with nothing expected, actual event %0d",
                             $time, event_res);
                end
                else
                begin
                    want = exp_q.pop_front();
                    compare_field("event_res", 16'(want.ev), 16'(event_res));
                    compare_field("line_length", 16'(want.line_len), 16'(line_length));
                    compare_field("fw_length", 16'(want.fw_len), 16'(fw_length));
                end
            end
            out_stall <= (n_recv >= 300 && n_recv < 450) ? 1'b0 : ($urandom_range(0, 99) < 20);
        end
    end

    // Stimulus and end of run
    initial
    begin : stim
        int                          pick;
        int                          len;
        int                          cnt;
        int                          k;
        int                          last_drain;
        logic [tild_pkg::BYTE_W-1:0] b;

        // directed: line with an escaped 0xFF, empty line
        queue_byte(8'h00);
        queue_byte(tild_pkg::IAC_BYTE);
        queue_byte(tild_pkg::IAC_BYTE);
        queue_byte(tild_pkg::CHAR_CR);
        queue_byte(tild_pkg::CHAR_LF);
        // WILL swallows its option, unknown command ignored
        queue_byte(tild_pkg::IAC_BYTE);
        queue_byte(tild_pkg::CMD_WILL);
        queue_byte(tild_pkg::OPT_TM);
        queue_byte(tild_pkg::IAC_BYTE);
        queue_byte(8'hF1);
        // timing mark, then timing mark after interrupt discards the line
        queue_byte(tild_pkg::IAC_BYTE);
        queue_byte(tild_pkg::CMD_DO);
        queue_byte(tild_pkg::OPT_TM);
        queue_byte(8'h7E);
        queue_byte(tild_pkg::IAC_BYTE);
        queue_byte(tild_pkg::CMD_IP);
        queue_byte(tild_pkg::IAC_BYTE);
        queue_byte(tild_pkg::CMD_DO);
        queue_byte(tild_pkg::OPT_TM);
        // rejected arms
        queue_arm(16'd0);
        queue_arm(16'hFFFF);
        queue_arm(16'(tild_pkg::FW_MAX + 1));
        // escape left pending across a capture; rearm during capture
        queue_byte(tild_pkg::IAC_BYTE);
        queue_arm(16'(tild_pkg::FW_MAX));
        queue_byte(tild_pkg::CHAR_LF);
        queue_arm(16'd2);
        queue_byte(tild_pkg::IAC_BYTE);
        queue_byte(tild_pkg::CMD_DO);
        queue_byte(tild_pkg::CMD_DO);
        queue_byte(tild_pkg::OPT_TM);

        // random part: mostly well-formed traffic, some noise
        drain_next = 1'b1;
        last_drain = n_queued;
        while (n_queued < 550)
        begin
            if (n_queued - last_drain > 120)
            begin
                drain_next = 1'b1;
                last_drain = n_queued;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                // text line, sometimes long enough to overflow
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
                for (k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        queue_byte(tild_pkg::IAC_BYTE);
                        queue_byte(tild_pkg::IAC_BYTE);
                    end
                    else
                    begin
                        b = 8'($urandom_range(0, 255));
                        if (b == tild_pkg::CHAR_LF || b == tild_pkg::CHAR_CR ||
                            b == tild_pkg::IAC_BYTE)
                            b = 8'($urandom_range(32, 126));
                        queue_byte(b);
                    end
                end
                queue_byte($urandom_range(0, 1) ? tild_pkg::CHAR_CR : tild_pkg::CHAR_LF);
            end
            else if (pick < 55)
            begin
                // option negotiation, sometimes after an interrupt
                if ($urandom_range(0, 2) == 0)
                begin
                    queue_byte(tild_pkg::IAC_BYTE);
                    queue_byte(tild_pkg::CMD_IP);
                end
                queue_byte(tild_pkg::IAC_BYTE);
                queue_byte($urandom_range(0, 1) ? tild_pkg::CMD_DO : tild_pkg::CMD_WILL);
                queue_byte($urandom_range(0, 1) ? tild_pkg::OPT_TM : 8'($urandom_range(0, 255)));
            end
            else if (pick < 65)
            begin
                queue_byte(tild_pkg::IAC_BYTE);
                queue_byte(8'($urandom_range(0, 255)));
            end
            else if (pick < 75)
            begin
                // firmware block, occasionally rearmed part way
                if ($urandom_range(0, 9) == 0)
                begin
                    queue_arm(16'(tild_pkg::FW_MAX));
                    repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)));
                end
                cnt = $urandom_range(1, 12);
                queue_arm(16'(cnt));
                if ($urandom_range(0, 7) == 0)
                begin
                    repeat ($urandom_range(0, cnt - 1)) queue_byte(8'($urandom_range(0, 255)));
                    cnt = $urandom_range(1, 12);
                    queue_arm(16'(cnt));
                end
                repeat (cnt) queue_byte(8'($urandom_range(0, 255)));
            end
            else if (pick < 80)
            begin
                k = $urandom_range(0, 3);
                if (k == 0)
                    queue_arm(16'd0);
                else if (k == 1)
                    queue_arm(16'hFFFF);
                else
                    queue_arm(16'($urandom_range(tild_pkg::FW_MAX + 1, 65535)));
            end
            else
            begin
                queue_byte(8'($urandom_range(0, 255)));
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // every queued item accepted and every expected result seen
        while (n_sent != n_queued || exp_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d items (lines, option negotiation, firmware blocks, noise),",
                 n_sent);
        $display("%0d results checked: %0d lines, %0d TM, %0d TM+CRLF, %0d blocks done, %0d/%0d arms",
                 n_recv, ev_cnt[tild_pkg::EV_LINE], ev_cnt[tild_pkg::EV_TM],
                 ev_cnt[tild_pkg::EV_TM_CRLF], ev_cnt[tild_pkg::EV_FW_DONE],
                 ev_cnt[tild_pkg::EV_ARM_OK], ev_cnt[tild_pkg::EV_ARM_BAD]);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Timeout: %0d sent, %0d received", n_sent, n_recv);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tild_pkg.sv
hdl/tild_front.sv
hdl/tild_fifo.sv
hdl/tild_back.sv
hdl/telnet_iac_line_deframer_core.sv
tb/sv/telnet_iac_line_deframer_core_tb.sv
